// ===== src/whr_pkg.sv =====
// Package for the half-spinor reconstruction block: float helpers, rotation tables.
// No dependencies.
`timescale 1ns / 1ps
package whr_pkg;

    localparam int NUM_DIR   = 4;
    localparam int NUM_SPIN  = 4;
    localparam int NUM_LANES = 8;

    localparam logic [31:0] CANON_NAN = 32'h7FC00000;
    localparam logic [31:0] SIGN_BIT  = 32'h80000000;

    localparam logic [0:0] CFG_MINUS = 1'd0;
    localparam logic [0:0] CFG_FOURTH = 1'd1;

    // Rotation codes: multiply by i^k
    localparam logic [1:0] ROT_P1 = 2'd0;
    localparam logic [1:0] ROT_PI = 2'd1;
    localparam logic [1:0] ROT_M1 = 2'd2;
    localparam logic [1:0] ROT_MI = 2'd3;

    typedef struct packed {
        logic minus;
        logic fourth;
    } cfg_t;

    function automatic logic [1:0] rot2_code(input logic [1:0] d);
        logic [1:0] r;
        case (d)
            2'd0: r = ROT_MI;
            2'd1: r = ROT_P1;
            2'd2: r = ROT_MI;
            default: r = ROT_P1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] rot3_code(input logic [1:0] d);
        logic [1:0] r;
        case (d)
            2'd0: r = ROT_MI;
            2'd1: r = ROT_M1;
            2'd2: r = ROT_PI;
            default: r = ROT_P1;
        endcase
        return r;
    endfunction

    // exact rotation of a packed complex {im, re}
    function automatic logic [63:0] rot(input logic [63:0] h, input logic [1:0] k);
        logic [31:0] re;
        logic [31:0] im;
        logic [63:0] r;
        re = h[31:0];
        im = h[63:32];
        case (k)
            ROT_P1: r = {im, re};
            ROT_PI: r = {re, im ^ SIGN_BIT};
            ROT_M1: r = {im ^ SIGN_BIT, re ^ SIGN_BIT};
            default: r = {re ^ SIGN_BIT, im};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] b);
        logic [31:0] r;
        if (b[30:23] == 8'hFF && b[22:0] != 23'd0)
            r = CANON_NAN;
        else
            r = b;
        return r;
    endfunction

endpackage

// ===== src/whr_fadd.sv =====
// Combinational single-precision adder, round to nearest even, full denormals.
// Depends on whr_pkg.
`timescale 1ns / 1ps
module whr_fadd
    import whr_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic        sa, sb, sl, ss;
    logic [7:0]  ea, eb, el, es;
    logic [23:0] ma, mb, ml, msm;
    logic [8:0]  d;
    logic [27:0] xl, xs, sh;
    logic [28:0] sum;
    logic        sticky;
    logic [4:0]  lz;
    logic [28:0] nrm;
    logic [24:0] mr;
    logic        rnd;
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic        found;
    logic [9:0]  er;

    always_comb
    begin
        sa = a[31]; sb = b[31];
        ea = a[30:23]; eb = b[30:23];
        ma = {ea != 8'd0, a[22:0]};
        mb = {eb != 8'd0, b[22:0]};
        a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
        swap = {eb, mb} > {ea, ma};
        sl = swap ? sb : sa;  ss = swap ? sa : sb;
        el = swap ? eb : ea;  es = swap ? ea : eb;
        ml = swap ? mb : ma;  msm = swap ? ma : mb;
        if (el == 8'd0) el = 8'd1;
        if (es == 8'd0) es = 8'd1;
        d = {1'b0, el} - {1'b0, es};
        xl = {1'b0, ml, 3'b000};
        xs = {1'b0, msm, 3'b000};
        if (d > 9'd27)
        begin
            sh = 28'd0;
            sticky = (msm != 24'd0);
        end
        else
        begin
            sh = xs >> d[4:0];
            sticky = ((xs & ((28'd1 << d[4:0]) - 28'd1)) != 28'd0);
        end
        sh[0] = sh[0] | sticky;
        if (sl == ss)
            sum = {1'b0, xl} + {1'b0, sh};
        else
            sum = {1'b0, xl} - {1'b0, sh};
        // leading one search; normalized so bit 27 holds the hidden bit
        lz = 5'd0;
        found = 1'b0;
        for (int i = 28; i >= 0; i--)
        begin
            if (!found && sum[i])
            begin
                found = 1'b1;
                lz = 5'(28 - i);
            end
        end
        // general normalize: shift left by lz-1 bounded by exponent
        nrm = sum;
        er = {2'b00, el} + 10'd1;
        if (lz == 5'd0)
        begin
            nrm = {1'b0, sum[28:1]};
            nrm[0] = sum[1] | sum[0];
            er = {2'b00, el} + 10'd1;
        end
        else
        begin
            if ({5'd0, lz} - 10'd1 > {2'b00, el})
            begin
                // result is subnormal: align to the minimum exponent
                nrm = sum << el;
                er = 10'd0;
            end
            else
            begin
                nrm = sum << (lz - 5'd1);
                er = {2'b00, el} - {5'd0, lz} + 10'd2;
            end
        end
        // nrm[27] hidden, [26:4] fraction, [3] guard, [2:0] sticky
        rnd = nrm[3] && ((nrm[2:0] != 3'd0) || nrm[4]);
        mr = {1'b0, nrm[27:4]} + {24'd0, rnd};
        if (mr[24])
        begin
            mr = mr >> 1;
            er = er + 10'd1;
        end
        if (er == 10'd0 && mr[23])
            er = 10'd1;
        if (a_nan || b_nan || (a_inf && b_inf && sa != sb))
            y = CANON_NAN;
        else if (a_inf)
            y = a;
        else if (b_inf)
            y = b;
        else if (sum == 29'd0)
            y = {sa & sb, 31'd0};
        else if (er >= 10'd255)
            y = {sl, 8'hFF, 23'd0};
        else
            y = {sl, mr[23] ? er[7:0] : 8'd0, mr[22:0]};
    end

endmodule

// ===== src/whr_lane.sv =====
// One spin lane: four chained complex adds, one register per direction stage.
// Depends on whr_pkg, whr_fadd.
`timescale 1ns / 1ps
module whr_lane
    import whr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] acc,
    input  logic [63:0] h0,
    input  logic [63:0] h1,
    input  logic [63:0] h2,
    input  logic [63:0] h3,
    input  logic        skip3,
    output logic [63:0] res
);

    logic [63:0] s_reg [NUM_DIR+1];
    logic [63:0] hp_reg [NUM_DIR][NUM_DIR];
    logic        skip_reg [NUM_DIR];
    logic [63:0] sum [NUM_DIR];

    // stage adders, one direction per stage
    for (genvar g = 0; g < NUM_DIR; g++)
    begin : g_stage
        whr_fadd u_re (.a(hp_reg[g][g][31:0]), .b(s_reg[g][31:0]), .y(sum[g][31:0]));
        whr_fadd u_im (.a(hp_reg[g][g][63:32]), .b(s_reg[g][63:32]), .y(sum[g][63:32]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= acc;
            hp_reg[0][0] <= h0; hp_reg[0][1] <= h1;
            hp_reg[0][2] <= h2; hp_reg[0][3] <= h3;
            skip_reg[0] <= skip3;
            for (int k = 1; k < NUM_DIR; k++)
            begin
                s_reg[k] <= sum[k-1];
                hp_reg[k] <= hp_reg[k-1];
                skip_reg[k] <= skip_reg[k-1];
            end
            s_reg[NUM_DIR] <= skip_reg[NUM_DIR-1] ? s_reg[NUM_DIR-1] : sum[NUM_DIR-1];
        end
    end

    assign res = {canon(s_reg[NUM_DIR][63:32]), canon(s_reg[NUM_DIR][31:0])};

endmodule

// ===== src/wilson_halfspinor_reconstruct.sv =====
// Top level: config registers, operand selection, four spin lanes, output valid line.
// Depends on whr_pkg, whr_lane.
`timescale 1ns / 1ps
// Usage:
//   Input channel: in_valid/in_stall with acc_spin0..3 and dirN_half_a/b.
//   Output channel: out_valid/out_stall with res_spin0..3.
//   Config: cfg_we, cfg_index, cfg_wdata; index 0 minus_sign_mode,
//   index 1 use_fourth_direction; written while idle.
//   Four lanes, one per spin, each a five-register pipeline with one
//   float add pair per direction stage. One word is taken every cycle
//   unless in_stall is high. The whole pipeline advances when the output
//   register is empty or being taken; a stall at the output freezes it
//   and raises in_stall. Reset clears valid bits and sets the
//   registers to plus signs and four directions.
module wilson_halfspinor_reconstruct
    import whr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] acc_spin0,
    input  logic [63:0] acc_spin1,
    input  logic [63:0] acc_spin2,
    input  logic [63:0] acc_spin3,
    input  logic [63:0] dir0_half_a,
    input  logic [63:0] dir0_half_b,
    input  logic [63:0] dir1_half_a,
    input  logic [63:0] dir1_half_b,
    input  logic [63:0] dir2_half_a,
    input  logic [63:0] dir2_half_b,
    input  logic [63:0] dir3_half_a,
    input  logic [63:0] dir3_half_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] res_spin0,
    output logic [63:0] res_spin1,
    output logic [63:0] res_spin2,
    output logic [63:0] res_spin3
);

    localparam int DEPTH = NUM_DIR + 1;

    cfg_t             cfg_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    logic [1:0]       flip;
    logic [63:0]      ha [NUM_DIR];
    logic [63:0]      hb [NUM_DIR];
    logic [63:0]      p2 [NUM_DIR];
    logic [63:0]      p3 [NUM_DIR];

    assign adv = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[DEPTH-1];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minus <= 1'b0;
            cfg_reg.fourth <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MINUS) cfg_reg.minus <= cfg_wdata[0];
            else cfg_reg.fourth <= cfg_wdata[0];
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // rotated operands for the lower spins
    assign ha = '{dir0_half_a, dir1_half_a, dir2_half_a, dir3_half_a};
    assign hb = '{dir0_half_b, dir1_half_b, dir2_half_b, dir3_half_b};
    assign flip = {cfg_reg.minus, 1'b0};
    always_comb
    begin
        for (int d = 0; d < NUM_DIR; d++)
        begin
            p2[d] = rot((d < 2) ? hb[d] : ha[d], rot2_code(2'(d)) + flip);
            p3[d] = rot((d < 2) ? ha[d] : hb[d], rot3_code(2'(d)) + flip);
        end
    end

    whr_lane u_s0 (.clk, .en(adv), .acc(acc_spin0), .h0(ha[0]), .h1(ha[1]), .h2(ha[2]),
                   .h3(ha[3]), .skip3(!cfg_reg.fourth), .res(res_spin0));
    whr_lane u_s1 (.clk, .en(adv), .acc(acc_spin1), .h0(hb[0]), .h1(hb[1]), .h2(hb[2]),
                   .h3(hb[3]), .skip3(!cfg_reg.fourth), .res(res_spin1));
    whr_lane u_s2 (.clk, .en(adv), .acc(acc_spin2), .h0(p2[0]), .h1(p2[1]), .h2(p2[2]),
                   .h3(p2[3]), .skip3(!cfg_reg.fourth), .res(res_spin2));
    whr_lane u_s3 (.clk, .en(adv), .acc(acc_spin3), .h0(p3[0]), .h1(p3[1]), .h2(p3[2]),
                   .h3(p3[3]), .skip3(!cfg_reg.fourth), .res(res_spin3));

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_spin0))
        else $error("result changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
`endif

endmodule
